/* rtl/core/enwsf_pkg.sv */
// types, constants and weights shared by the edge normalised smoothing filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package enwsf_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WIN_SHIFT       = 5;
  localparam int ACC_GROWTH      = 5;
  localparam int WSUM_BITS       = 6;
  localparam int TAP_COUNT       = 5;
  localparam int WIN_LEN         = 7;
  localparam int MODE_BITS       = 2;

  localparam logic [MODE_BITS-1:0] MODE_PASS = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_TRI  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_W5   = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_RST  = MODE_W5;

  localparam logic [4:0] TAP_WEIGHT [TAP_COUNT] = '{5'd3, 5'd7, 5'd12, 5'd7, 5'd3};

  typedef struct packed {
    logic load;
    logic calc;
    logic div_go;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic has_res;
    logic need_div;
    logic div_done;
    logic div_busy;
    logic out_free;
    logic final_res;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/enwsf_if.sv */
// valid/ready channels for input samples and smoothed results
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface enwsf_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_in;

  modport source (output valid, output sample, output last_in, input ready);
  modport sink (input valid, input sample, input last_in, output ready);
endinterface

interface enwsf_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] smoothed;
  logic                          last_out;

  modport source (output valid, output smoothed, output last_out, input ready);
  modport sink (input valid, input smoothed, input last_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/enwsf_div.sv */
// restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on enwsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module enwsf_div #(
  parameter int DIVIDEND_BITS = enwsf_pkg::SAMPLE_BITS_DEF + enwsf_pkg::ACC_GROWTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [DIVIDEND_BITS-1:0]           dividend,
  input  wire logic [enwsf_pkg::WSUM_BITS-1:0]    divisor,
  output logic      [DIVIDEND_BITS-1:0]           quot,
  output logic                                    busy,
  output logic                                    done
);
  import enwsf_pkg::*;

  localparam int CW = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] qr;
  logic [WSUM_BITS-1:0]     rem;
  logic [CW-1:0]            cnt;
  logic [WSUM_BITS:0]       trial;
  logic [WSUM_BITS:0]       diff;
  logic                     ge;

  always_comb begin
    trial = {rem, qr[DIVIDEND_BITS-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIVIDEND_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr  <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[WSUM_BITS-1:0] : trial[WSUM_BITS-1:0];
      qr  <= {qr[DIVIDEND_BITS-2:0], ge};
    end
  end

  assign quot = qr;

endmodule

`default_nettype wire

/* rtl/core/enwsf_datapath.sv */
// history, window, tap arithmetic, edge divider and output register
// depends on enwsf_pkg and enwsf_div
`timescale 1ns / 1ps
`default_nettype none

module enwsf_datapath #(
  parameter int SAMPLE_BITS = enwsf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire enwsf_pkg::cmd_t                   cmd,
  output enwsf_pkg::stat_t                       stat,
  input  wire logic                              cfg_we,
  input  wire logic [enwsf_pkg::MODE_BITS-1:0]   cfg_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  wire logic                              in_last,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic signed [SAMPLE_BITS-1:0]          out_smoothed,
  output logic                                   out_last
);
  import enwsf_pkg::*;

  localparam int ACCW = SAMPLE_BITS + ACC_GROWTH;
  localparam int TRIW = SAMPLE_BITS + 2;

  logic [MODE_BITS-1:0]          mode;
  logic signed [SAMPLE_BITS-1:0] hist [4];
  logic [2:0]                    run_pos;

  logic signed [SAMPLE_BITS-1:0] win [WIN_LEN];
  logic [WIN_LEN-1:0]            have;
  logic [1:0]                    j;
  logic                          last_q;

  logic signed [SAMPLE_BITS-1:0] tap [TAP_COUNT];
  logic [TAP_COUNT-1:0]          tap_have;
  logic signed [ACCW-1:0]        prod [TAP_COUNT];
  logic signed [ACCW-1:0]        acc_c;
  logic [WSUM_BITS-1:0]          wsum_c;
  logic                          full;
  logic signed [ACCW-1:0]        acc_sh;
  logic signed [TRIW-1:0]        tri_sum;
  logic signed [TRIW-1:0]        tri_sh;
  logic signed [SAMPLE_BITS-1:0] res_c;
  logic [2:0]                    first_c;

  logic signed [ACCW-1:0]        acc_q;
  logic [WSUM_BITS-1:0]          wsum_q;
  logic signed [SAMPLE_BITS-1:0] res;
  logic                          use_div;
  logic                          neg_q;
  logic [ACCW-1:0]               mag;
  logic [ACCW-1:0]               quot;
  logic [ACCW-1:0]               quot_s;
  logic                          div_busy;
  logic                          div_done;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RST;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // history and run position
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        hist[k] <= '0;
      end
      run_pos <= '0;
    end else if (cmd.load) begin
      if (in_last) begin
        for (int k = 0; k < 4; k++) begin
          hist[k] <= '0;
        end
        run_pos <= '0;
      end else begin
        hist[0] <= in_sample;
        for (int k = 1; k < 4; k++) begin
          hist[k] <= hist[k-1];
        end
        if (run_pos < 3'd4) begin
          run_pos <= run_pos + 3'd1;
        end
      end
    end
  end

  assign first_c = 3'd2 - run_pos;

  // window snapshot
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 4; k++) begin
        win[k] <= hist[3-k];
      end
      win[4] <= in_sample;
      win[5] <= '0;
      win[6] <= '0;
      for (int k = 0; k < WIN_LEN; k++) begin
        have[k] <= (k < TAP_COUNT) && (({1'b0, run_pos} + 4'(k)) >= 4'd4);
      end
      last_q <= in_last;
      j      <= (run_pos >= 3'd2) ? 2'd0 : first_c[1:0];
    end else if (cmd.emit) begin
      j <= j + 2'd1;
    end
  end

  // taps of the current window
  always_comb begin
    for (int k = 0; k < TAP_COUNT; k++) begin
      tap[k]      = win[3'(j) + 3'(k)];
      tap_have[k] = have[3'(j) + 3'(k)];
      prod[k]     = tap_have[k] ? (ACCW'(tap[k]) * signed'(ACCW'(TAP_WEIGHT[k]))) : '0;
    end
    acc_c  = '0;
    wsum_c = '0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      acc_c  = acc_c + prod[k];
      wsum_c = wsum_c + (tap_have[k] ? WSUM_BITS'(TAP_WEIGHT[k]) : '0);
    end
    full    = &tap_have;
    acc_sh  = acc_c >>> WIN_SHIFT;
    tri_sum = TRIW'(tap[1]) + (TRIW'(tap[2]) <<< 1) + TRIW'(tap[3]);
    tri_sh  = tri_sum >>> 2;
    case (mode)
      MODE_W5: begin
        res_c = acc_sh[SAMPLE_BITS-1:0];
      end
      MODE_TRI: begin
        res_c = (tap_have[1] && tap_have[3]) ? tri_sh[SAMPLE_BITS-1:0] : tap[2];
      end
      default: begin
        res_c = tap[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      res     <= res_c;
      use_div <= (mode == MODE_W5) && !full;
      acc_q   <= acc_c;
      wsum_q  <= wsum_c;
    end
  end

  // edge normalisation: sign and magnitude around the divider
  assign neg_q = acc_q[ACCW-1];
  assign mag   = neg_q ? ACCW'(-acc_q) : ACCW'(acc_q);

  enwsf_div #(
    .DIVIDEND_BITS (ACCW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (mag),
    .divisor  (wsum_q),
    .quot     (quot),
    .busy     (div_busy),
    .done     (div_done)
  );

  assign quot_s = neg_q ? (~quot + 1'b1) : quot;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_smoothed <= use_div ? signed'(quot_s[SAMPLE_BITS-1:0]) : res;
      out_last     <= last_q && (j == 2'd2);
    end
  end

  always_comb begin
    stat.has_res   = in_last || (run_pos >= 3'd2);
    stat.need_div  = (mode == MODE_W5) && !full;
    stat.div_done  = div_done;
    stat.div_busy  = div_busy;
    stat.out_free  = !out_valid || out_ready;
    stat.final_res = !last_q || (j == 2'd2);
  end

endmodule

`default_nettype wire

/* rtl/core/enwsf_ctrl.sv */
// controller: sequences load, tap sum, edge division and output per result
// depends on enwsf_pkg
`timescale 1ns / 1ps
`default_nettype none

module enwsf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output enwsf_pkg::cmd_t        cmd,
  input  wire enwsf_pkg::stat_t  stat
);
  import enwsf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_DLD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.has_res) begin
            state_next = S_CALC;
          end
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = stat.need_div ? S_DLD : S_OUT;
      end
      S_DLD: begin
        cmd.div_go = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.final_res ? S_IDLE : S_CALC;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/edge_normalized_smoothing_filter_core.sv */
// sequence: each result of an accepted item passes S_CALC, then S_OUT, which
//   waits for a free output; S_DLD and S_DIV (divider) lie between them where
//   a run edge cuts a five-tap window; a new item is taken only in S_IDLE, once
//   the prior item's results are emitted; a last item gives up to 3 results
// reset: clears history, run position, output valid; mode returns to 2 (MODE_W5)
`timescale 1ns / 1ps
`default_nettype none

module edge_normalized_smoothing_filter_core #(
  parameter int SAMPLE_BITS = enwsf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [enwsf_pkg::MODE_BITS-1:0] cfg_wdata,
  enwsf_in_if.sink                             in_ch,
  enwsf_out_if.source                          out_ch
);
  import enwsf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  enwsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  enwsf_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_sample    (in_ch.sample),
    .in_last      (in_ch.last_in),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_smoothed (out_ch.smoothed),
    .out_last     (out_ch.last_out)
  );

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result written over an item not yet taken");

  a_no_accept_div: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> !in_ch.ready)
    else $error("input ready during division");

  a_div_after_go: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |=> stat.div_busy)
    else $error("divider did not start");
`endif

endmodule

`default_nettype wire
